FILE: rtl/uasr_pkg.sv
// ----------------------------------------------------------------------------
// uasr_pkg
// Shared constants, result codes and types of the ustar stream reader.
// ----------------------------------------------------------------------------
package uasr_pkg;

    // archive block geometry
    localparam int BLOCK_BYTES = 512;
    localparam int OFF_W       = $clog2(BLOCK_BYTES);

    // header field offsets
    localparam int SUM_START   = 148;
    localparam int SUM_END     = 156;
    localparam int SIZE_START  = 124;
    localparam int SIZE_END    = 136;
    localparam int TYPE_OFF    = 156;
    localparam int NAME_BYTES  = 100;

    // field widths
    localparam int HSUM_W      = 17;
    localparam int CSUM_W      = 24;
    localparam int SIZE_W      = 36;
    localparam int REGION_W    = SIZE_W + 1;

    // characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DIR   = 8'h35;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // input function codes
    localparam logic FN_BYTE = 1'b0;
    localparam logic FN_END  = 1'b1;

    // result kinds
    typedef logic [2:0] t_kind;
    localparam t_kind K_PAYLOAD = 3'd0;
    localparam t_kind K_HEADER  = 3'd1;
    localparam t_kind K_CLEAN   = 3'd2;
    localparam t_kind K_TRUNC   = 3'd3;
    localparam t_kind K_BADSUM  = 3'd4;

    // header accumulator status, values include the byte now being taken
    typedef struct packed {
        logic              offset_zero;
        logic              last_byte;
        logic              nonzero;
        logic              sum_ok;
        logic [SIZE_W-1:0] size;
        logic [7:0]        type_byte;
        logic              unsafe;
    } t_hdr_status;

endpackage

FILE: rtl/uasr_hdr_acc.sv
// ----------------------------------------------------------------------------
// uasr_hdr_acc
// Per-byte header accumulation: checksum sum, octal checksum and size
// fields, type byte, zero-block flag and name safety. Clears itself after
// the last byte of the header block.
// ----------------------------------------------------------------------------
module uasr_hdr_acc (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    output uasr_pkg::t_hdr_status o_status
);
    import uasr_pkg::*;

    logic [OFF_W-1:0]  r_offset,  n_offset;
    logic [HSUM_W-1:0] r_sum,     n_sum;
    logic [CSUM_W-1:0] r_stored,  n_stored;
    logic              r_stored_open, n_stored_open;
    logic [SIZE_W-1:0] r_size,    n_size;
    logic              r_size_open,   n_size_open;
    logic [7:0]        r_type,    n_type;
    logic              r_nonzero, n_nonzero;
    logic              r_ended,   n_ended;
    logic              r_prevdot, n_prevdot;
    logic              r_unsafe,  n_unsafe;

    logic       w_octal;
    logic [2:0] w_digit;
    logic       w_in_sum;
    logic       w_in_size;
    logic       w_first;
    logic       w_last;

    assign w_octal   = (i_byte[7:3] == CH_ZERO[7:3]);
    assign w_digit   = i_byte[2:0];
    assign w_in_sum  = (r_offset >= OFF_W'(SUM_START)) && (r_offset < OFF_W'(SUM_END));
    assign w_in_size = (r_offset >= OFF_W'(SIZE_START)) && (r_offset < OFF_W'(SIZE_END));
    assign w_first   = (r_offset == '0);
    assign w_last    = (r_offset == OFF_W'(BLOCK_BYTES - 1));

    // next header values for the current byte
    always_comb begin
        n_offset      = r_offset + OFF_W'(1);
        n_sum         = r_sum;
        n_stored      = r_stored;
        n_stored_open = r_stored_open;
        n_size        = r_size;
        n_size_open   = r_size_open;
        n_type        = r_type;
        n_nonzero     = r_nonzero | (i_byte != 8'h00);
        n_ended       = r_ended;
        n_prevdot     = r_prevdot;
        n_unsafe      = r_unsafe;

        // checksum field counts as spaces
        if (w_in_sum) begin
            n_sum = r_sum + HSUM_W'(CH_SPACE);
            if (r_stored_open) begin
                if (w_octal) begin
                    n_stored = {r_stored[CSUM_W-4:0], w_digit};
                end else begin
                    n_stored_open = 1'b0;
                end
            end
        end else begin
            n_sum = r_sum + HSUM_W'(i_byte);
        end

        // octal size field
        if (w_in_size && r_size_open) begin
            if (w_octal) begin
                n_size = {r_size[SIZE_W-4:0], w_digit};
            end else begin
                n_size_open = 1'b0;
            end
        end

        if (r_offset == OFF_W'(TYPE_OFF)) begin
            n_type = i_byte;
        end

        // name safety up to the first nul
        if ((r_offset < OFF_W'(NAME_BYTES)) && !r_ended) begin
            if (i_byte == 8'h00) begin
                n_ended = 1'b1;
                if (w_first) begin
                    n_unsafe = 1'b1;
                end
            end else begin
                if (w_first && (i_byte == CH_SLASH)) begin
                    n_unsafe = 1'b1;
                end
                if (i_byte == CH_DOT) begin
                    if (r_prevdot) begin
                        n_unsafe = 1'b1;
                    end
                    n_prevdot = 1'b1;
                end else begin
                    n_prevdot = 1'b0;
                end
            end
        end
    end

    // status seen by the control logic
    assign o_status.offset_zero = w_first;
    assign o_status.last_byte   = w_last;
    assign o_status.nonzero     = n_nonzero;
    assign o_status.sum_ok      = ({{(CSUM_W-HSUM_W){1'b0}}, n_sum} == n_stored);
    assign o_status.size        = n_size;
    assign o_status.type_byte   = n_type;
    assign o_status.unsafe      = n_unsafe;

    // header registers, cleared after the last byte of the block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && w_last)) begin
            r_offset      <= '0;
            r_sum         <= '0;
            r_stored      <= '0;
            r_stored_open <= 1'b1;
            r_size        <= '0;
            r_size_open   <= 1'b1;
            r_type        <= '0;
            r_nonzero     <= 1'b0;
            r_ended       <= 1'b0;
            r_prevdot     <= 1'b0;
            r_unsafe      <= 1'b0;
        end else if (i_step) begin
            r_offset      <= n_offset;
            r_sum         <= n_sum;
            r_stored      <= n_stored;
            r_stored_open <= n_stored_open;
            r_size        <= n_size;
            r_size_open   <= n_size_open;
            r_type        <= n_type;
            r_nonzero     <= n_nonzero;
            r_ended       <= n_ended;
            r_prevdot     <= n_prevdot;
            r_unsafe      <= n_unsafe;
        end
    end

endmodule

FILE: rtl/ustar_archive_stream_reader_core.sv
// ----------------------------------------------------------------------------
// ustar_archive_stream_reader_core
// Byte-stream ustar archive reader: header checks and payload streaming.
// ----------------------------------------------------------------------------
// One archive byte (or an end-of-input marker) is taken per cycle and passes
// an input register, the header/data logic and a result register, so the
// sustained rate is one transaction per cycle; only a stalled result register
// holds the input side back, after the input register
// has filled. Each 512-byte header yields one result: header
// accepted, clean end on an all-zero block, or bad checksum. Payload bytes
// follow when extracting, with block padding, directories and unsafe names
// dropped; list_only suppresses all payload. After any end or error result
// the reader stays stopped until reset.
module ustar_archive_stream_reader_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_wr_en,
    input  logic                        i_cfg_wr_data,
    // archive input
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_func,
    input  logic [7:0]                  i_byte_value,
    // results
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [2:0]                  o_result_kind,
    output logic [7:0]                  o_payload_byte,
    output logic                        o_last_payload,
    output logic [uasr_pkg::SIZE_W-1:0] o_entry_size,
    output logic [7:0]                  o_entry_type,
    output logic                        o_name_unsafe
);
    import uasr_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_DATA,
        PH_STOPPED
    } t_phase;

    t_phase              r_phase;
    logic                r_list_only;
    logic                r_in_valid;
    logic                r_in_func;
    logic [7:0]          r_in_byte;
    logic [REGION_W-1:0] r_region;
    logic [SIZE_W-1:0]   r_payload;
    logic                r_skip;

    logic                r_out_valid;
    t_kind               r_kind;
    logic [7:0]          r_pbyte;
    logic                r_last;
    logic [SIZE_W-1:0]   r_size;
    logic [7:0]          r_type;
    logic                r_unsafe;

    logic                w_adv;
    logic                w_proc;
    logic                w_hdr_step;
    t_hdr_status         w_hdr;

    t_phase              n_phase;
    logic [REGION_W-1:0] n_region;
    logic [SIZE_W-1:0]   n_payload;
    logic                n_skip;
    logic                n_has;
    t_kind               n_kind;
    logic [7:0]          n_pbyte;
    logic                n_last;
    logic [SIZE_W-1:0]   n_size;
    logic [7:0]          n_type;
    logic                n_unsafe;
    logic [REGION_W-1:0] w_round;
    logic [REGION_W-1:0] w_region_dec;

    // pipeline flow
    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_proc     = r_in_valid && w_adv;
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_hdr_step = w_proc && (r_phase == PH_HEADER) && (r_in_func == FN_BYTE);

    uasr_hdr_acc u_hdr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_hdr_step),
        .i_byte   (r_in_byte),
        .o_status (w_hdr)
    );

    assign w_round      = ({1'b0, w_hdr.size} + REGION_W'(BLOCK_BYTES - 1))
                          & ~REGION_W'(BLOCK_BYTES - 1);
    assign w_region_dec = r_region - REGION_W'(1);

    // per-transaction control and result selection
    always_comb begin
        n_phase   = r_phase;
        n_region  = r_region;
        n_payload = r_payload;
        n_skip    = r_skip;
        n_has     = 1'b0;
        n_kind    = K_PAYLOAD;
        n_pbyte   = '0;
        n_last    = 1'b0;
        n_size    = '0;
        n_type    = '0;
        n_unsafe  = 1'b0;

        if (r_phase != PH_STOPPED) begin
            if (r_in_func == FN_END) begin
                n_has   = 1'b1;
                n_phase = PH_STOPPED;
                if (r_phase == PH_HEADER) begin
                    n_kind = w_hdr.offset_zero ? K_CLEAN : K_TRUNC;
                end else begin
                    n_kind = r_list_only ? K_CLEAN : K_TRUNC;
                end
            end else if (r_phase == PH_HEADER) begin
                if (w_hdr.last_byte) begin
                    n_has = 1'b1;
                    if (!w_hdr.nonzero) begin
                        n_kind  = K_CLEAN;
                        n_phase = PH_STOPPED;
                    end else if (!w_hdr.sum_ok) begin
                        n_kind  = K_BADSUM;
                        n_phase = PH_STOPPED;
                    end else begin
                        n_kind    = K_HEADER;
                        n_size    = w_hdr.size;
                        n_type    = w_hdr.type_byte;
                        n_unsafe  = w_hdr.unsafe;
                        n_payload = w_hdr.size;
                        n_region  = w_round;
                        n_skip    = r_list_only || w_hdr.unsafe || (w_hdr.type_byte == CH_DIR);
                        n_phase   = (w_round != '0) ? PH_DATA : PH_HEADER;
                    end
                end
            end else begin
                // data region walk
                n_region = w_region_dec;
                if (!r_skip && (r_payload != '0)) begin
                    n_has     = 1'b1;
                    n_kind    = K_PAYLOAD;
                    n_pbyte   = r_in_byte;
                    n_payload = r_payload - SIZE_W'(1);
                    n_last    = (r_payload == SIZE_W'(1));
                end
                if (w_region_dec == '0) begin
                    n_phase   = PH_HEADER;
                    n_payload = '0;
                end
            end
        end
    end

    // state, input register and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_list_only <= 1'b0;
            r_in_valid  <= 1'b0;
            r_region    <= '0;
            r_payload   <= '0;
            r_skip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_list_only <= i_cfg_wr_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
                r_in_func  <= i_func;
                r_in_byte  <= i_byte_value;
            end
            if (w_adv) begin
                r_out_valid <= w_proc && n_has;
            end
            if (w_proc) begin
                r_phase   <= n_phase;
                r_region  <= n_region;
                r_payload <= n_payload;
                r_skip    <= n_skip;
                if (n_has) begin
                    r_kind   <= n_kind;
                    r_pbyte  <= n_pbyte;
                    r_last   <= n_last;
                    r_size   <= n_size;
                    r_type   <= n_type;
                    r_unsafe <= n_unsafe;
                end
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_kind;
    assign o_payload_byte = r_pbyte;
    assign o_last_payload = r_last;
    assign o_entry_size   = r_size;
    assign o_entry_type   = r_type;
    assign o_name_unsafe  = r_unsafe;

endmodule

FILE: rtl/uasr_checker.sv
// ----------------------------------------------------------------------------
// uasr_checker
// Port-level checks of the ustar stream reader, bound to the top level.
// ----------------------------------------------------------------------------
module uasr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [2:0]                  o_result_kind,
    input logic [7:0]                  o_payload_byte,
    input logic                        o_last_payload,
    input logic [uasr_pkg::SIZE_W-1:0] o_entry_size,
    input logic [7:0]                  o_entry_type,
    input logic                        o_name_unsafe
);
    import uasr_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_result_kind) && $stable(o_payload_byte)))
        else $error("stalled result changed");

    // last marker only on payload bytes
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_payload) |-> (o_result_kind == K_PAYLOAD))
        else $error("last marker on non-payload result");

    // header fields are zero outside header results
    a_hdr_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_result_kind != K_HEADER)) |->
            ((o_entry_size == '0) && (o_entry_type == '0) && !o_name_unsafe))
        else $error("header fields on non-header result");

    // nothing follows an end or error result
    a_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready &&
            ((o_result_kind == K_CLEAN) || (o_result_kind == K_TRUNC) ||
             (o_result_kind == K_BADSUM))) |=> !o_out_valid)
        else $error("result after stop");

endmodule

bind ustar_archive_stream_reader_core uasr_checker u_uasr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_result_kind  (o_result_kind),
    .o_payload_byte (o_payload_byte),
    .o_last_payload (o_last_payload),
    .o_entry_size   (o_entry_size),
    .o_entry_type   (o_entry_type),
    .o_name_unsafe  (o_name_unsafe)
);

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ustar stream reader core: builds archives of
// generated headers and data regions, predicts every header, payload and end
// result in a local model of the reader and checks each output transaction.
// ----------------------------------------------------------------------------
// The reader only leaves its stopped state through reset, and reset is
// applied once, so a run ends with exactly one end condition, picked at
// random: all-zero block, end at a boundary, end inside a header, end inside
// data (small or huge entry) or a bad checksum.
module tb;
    import uasr_pkg::*;

    localparam int  RANDOM_ITEMS  = 550;
    localparam int  SETTLE_CYCLES = 4;
    localparam int  LIMIT_CYCLES  = 400000;
    localparam int  HOLD_CYCLES   = 300;

    typedef enum logic [1:0] {RD_HEADER, RD_DATA, RD_STOPPED} t_rd_phase;

    typedef enum int {
        NM_PLAIN, NM_DOTS_SAFE, NM_EMPTY, NM_ABS, NM_DOTDOT, NM_FULL, NM_NOISE,
        NM_DOTS_AFTER_END
    } t_name_style;

    typedef enum int {
        END_ZERO_BLOCK, END_AT_BOUNDARY, END_IN_HEADER, END_IN_HUGE_DATA,
        END_BAD_SUM, END_IN_DATA
    } t_end_style;

    typedef struct packed {
        logic [2:0]        kind;
        logic [7:0]        payload;
        logic              last_flag;
        logic [SIZE_W-1:0] entry_size;
        logic [7:0]        entry_type;
        logic              name_bad;
    } t_reader_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic                i_cfg_wr_data;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_func;
    logic [7:0]          i_byte_value;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [2:0]          o_result_kind;
    logic [7:0]          o_payload_byte;
    logic                o_last_payload;
    logic [SIZE_W-1:0]   o_entry_size;
    logic [7:0]          o_entry_type;
    logic                o_name_unsafe;

    ustar_archive_stream_reader_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_byte_value   (i_byte_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_kind  (o_result_kind),
        .o_payload_byte (o_payload_byte),
        .o_last_payload (o_last_payload),
        .o_entry_size   (o_entry_size),
        .o_entry_type   (o_entry_type),
        .o_name_unsafe  (o_name_unsafe)
    );

    // bench state
    t_reader_result    expected_results[$];
    int                mismatch_count = 0;
    int                items_sent = 0;
    int                cycle_count = 0;
    int                rx_hold_left = 0;
    bit                steady = 1'b0;
    logic [7:0]        hdr_buf [0:BLOCK_BYTES-1];

    // mirror of the reader
    logic              list_only_m;
    t_rd_phase         rd_phase;
    logic [8:0]        blk_off;
    logic [HSUM_W-1:0] hdr_sum;
    logic [CSUM_W-1:0] csum_val;
    logic              csum_open;
    logic [SIZE_W-1:0] size_val;
    logic              size_open;
    logic [7:0]        type_b;
    logic              any_nonzero;
    logic              name_ended;
    logic              name_prevdot;
    logic              name_bad;
    logic [REGION_W-1:0] region_left;
    logic [SIZE_W-1:0] payload_left;
    logic              skip_entry;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("ustar_archive_stream_reader_core: mismatch");
        $finish;
    end

    function automatic logic is_octal(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_ZERO + 8'd7);
    endfunction

    function automatic int octal_digits(input logic [SIZE_W-1:0] value);
        int n;
        n = 1;
        while (n < 12 && (value >> (3 * n)) != 0) n++;
        return n;
    endfunction

    function automatic logic [7:0] non_octal_byte();
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 2) == 0) v = 8'h00;
        else if (is_octal(v)) v = CH_SPACE;
        return v;
    endfunction

    function automatic longint region_len(input logic [SIZE_W-1:0] size);
        longint s;
        s = size;
        return ((s + 511) / 512) * 512;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("[%0d] %s: got %0h, expected %0h", cycle_count, what, got, want);
    endtask

    // append one expectation at the tail of the queue
    task automatic queue_result(input t_reader_result r);
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic clear_header_state();
        blk_off      = '0;
        hdr_sum      = '0;
        csum_val     = '0;
        csum_open    = 1'b1;
        size_val     = '0;
        size_open    = 1'b1;
        type_b       = '0;
        any_nonzero  = 1'b0;
        name_ended   = 1'b0;
        name_prevdot = 1'b0;
        name_bad     = 1'b0;
    endtask

    // expected results of one accepted input transaction
    task automatic predict_archive_step(input logic f, input logic [7:0] b);
        t_reader_result r;
        logic           at_last;
        logic [8:0]     off;
        r = '0;
        if (rd_phase == RD_STOPPED) begin
            // stopped until reset
        end else if (f == FN_END) begin
            if (rd_phase == RD_HEADER) r.kind = (blk_off == 0) ? K_CLEAN : K_TRUNC;
            else r.kind = list_only_m ? K_CLEAN : K_TRUNC;
            rd_phase = RD_STOPPED;
            queue_result(r);
        end else if (rd_phase == RD_HEADER) begin
            at_last = (blk_off == BLOCK_BYTES - 1);
            off = blk_off;
            // checksum field counts as spaces
            if (off >= SUM_START && off < SUM_END) begin
                hdr_sum = hdr_sum + CH_SPACE;
                if (csum_open) begin
                    if (is_octal(b)) csum_val = {csum_val[CSUM_W-4:0], b[2:0]};
                    else csum_open = 1'b0;
                end
            end else begin
                hdr_sum = hdr_sum + b;
            end
            if (off >= SIZE_START && off < SIZE_END && size_open) begin
                if (is_octal(b)) size_val = {size_val[SIZE_W-4:0], b[2:0]};
                else size_open = 1'b0;
            end
            if (off == TYPE_OFF) type_b = b;
            if (b != 8'h00) any_nonzero = 1'b1;
            // name safety up to the first nul
            if (off < NAME_BYTES && !name_ended) begin
                if (b == 8'h00) begin
                    name_ended = 1'b1;
                    if (off == 0) name_bad = 1'b1;
                end else begin
                    if (off == 0 && b == CH_SLASH) name_bad = 1'b1;
                    if (b == CH_DOT) begin
                        if (name_prevdot) name_bad = 1'b1;
                        name_prevdot = 1'b1;
                    end else begin
                        name_prevdot = 1'b0;
                    end
                end
            end
            blk_off = blk_off + 9'd1;
            if (at_last) begin
                if (!any_nonzero) begin
                    r.kind = K_CLEAN;
                    rd_phase = RD_STOPPED;
                    queue_result(r);
                end else if ({{(CSUM_W-HSUM_W){1'b0}}, hdr_sum} != csum_val) begin
                    r.kind = K_BADSUM;
                    rd_phase = RD_STOPPED;
                    queue_result(r);
                end else begin
                    r.kind       = K_HEADER;
                    r.entry_size = size_val;
                    r.entry_type = type_b;
                    r.name_bad   = name_bad;
                    queue_result(r);
                    payload_left = size_val;
                    region_left  = ({1'b0, size_val} + 37'd511) & ~37'd511;
                    skip_entry   = list_only_m || name_bad || (type_b == CH_DIR);
                    clear_header_state();
                    rd_phase = (region_left != 0) ? RD_DATA : RD_HEADER;
                end
            end
        end else begin
            // data region, padding dropped
            if (region_left != 0) region_left = region_left - 1'b1;
            if (!skip_entry && payload_left != 0) begin
                payload_left = payload_left - 1'b1;
                r.kind      = K_PAYLOAD;
                r.payload   = b;
                r.last_flag = (payload_left == 0);
                queue_result(r);
            end
            if (region_left == 0) begin
                rd_phase = RD_HEADER;
                payload_left = '0;
                clear_header_state();
            end
        end
    endtask

    // one input transaction, with random idle cycles ahead of it
    task automatic send_item(input logic f, input logic [7:0] b);
        if (!steady && $urandom_range(0, 99) < 10) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_func       <= f;
        i_byte_value <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        predict_archive_step(f, b);
    endtask

    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_list_only(input logic v);
        wait_results_done();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        list_only_m = v;
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic fill_name(input t_name_style ns);
        int len;
        int p;
        int i;
        len = $urandom_range(1, NAME_BYTES - 1);
        for (i = 0; i < NAME_BYTES; i++) begin
            if (i < len) hdr_buf[i] = 8'($urandom_range(8'h61, 8'h7A));
            else if (i == len) hdr_buf[i] = 8'h00;
            else hdr_buf[i] = 8'($urandom_range(0, 255));
        end
        case (ns)
            NM_DOTS_SAFE: begin
                for (i = 1; i < len; i += 2)
                    hdr_buf[i] = ($urandom_range(0, 1) == 1) ? CH_DOT : CH_SLASH;
            end
            NM_EMPTY: hdr_buf[0] = 8'h00;
            NM_ABS:   hdr_buf[0] = CH_SLASH;
            NM_DOTDOT: begin
                p = $urandom_range(0, NAME_BYTES - 2);
                for (i = 0; i < p; i++)
                    if (hdr_buf[i] == 8'h00) hdr_buf[i] = 8'h61;
                hdr_buf[p]   = CH_DOT;
                hdr_buf[p+1] = CH_DOT;
            end
            NM_FULL: begin
                for (i = 0; i < NAME_BYTES; i++)
                    hdr_buf[i] = 8'($urandom_range(8'h61, 8'h7A));
            end
            NM_NOISE: begin
                for (i = 0; i < NAME_BYTES; i++) hdr_buf[i] = 8'($urandom_range(0, 255));
            end
            NM_DOTS_AFTER_END: begin
                // dots past the nul are not part of the name
                if (len <= NAME_BYTES - 3) begin
                    hdr_buf[len+1] = CH_DOT;
                    hdr_buf[len+2] = CH_DOT;
                end
            end
            default: ;
        endcase
    endtask

    // octal digits, then a non-octal stop if the field has room, and arbitrary tail
    task automatic put_octal(input int start, input int field_len,
                             input logic [SIZE_W-1:0] value, input int ndig);
        int i;
        logic [SIZE_W-1:0] digit;
        for (i = 0; i < field_len; i++) begin
            if (i < ndig) begin
                digit = value >> (3 * (ndig - 1 - i));
                hdr_buf[start+i] = CH_ZERO + {5'd0, digit[2:0]};
            end else if (i == ndig) begin
                hdr_buf[start+i] = non_octal_byte();
            end else begin
                hdr_buf[start+i] = 8'($urandom_range(0, 255));
            end
        end
    endtask

    // build one header block and send its first nbytes bytes
    task automatic send_header(input t_name_style ns, input logic [SIZE_W-1:0] size,
                               input logic [7:0] etype, input bit bad_sum,
                               input int nbytes);
        int i;
        int ndig;
        bit noisy;
        logic [CSUM_W-1:0] sum;
        noisy = ($urandom_range(0, 3) == 0);
        fill_name(ns);
        for (i = NAME_BYTES; i < BLOCK_BYTES; i++)
            hdr_buf[i] = noisy ? 8'($urandom_range(0, 255)) : 8'h00;
        if (size == 0 && $urandom_range(0, 3) == 0) ndig = 0;
        else ndig = $urandom_range(octal_digits(size), SIZE_END - SIZE_START);
        put_octal(SIZE_START, SIZE_END - SIZE_START, size, ndig);
        hdr_buf[TYPE_OFF] = etype;
        sum = CSUM_W'(8 * CH_SPACE);
        for (i = 0; i < BLOCK_BYTES; i++)
            if (i < SUM_START || i >= SUM_END) sum = sum + CSUM_W'(hdr_buf[i]);
        if (bad_sum) sum = sum ^ (24'd1 << $urandom_range(0, HSUM_W - 1));
        put_octal(SUM_START, SUM_END - SUM_START, {12'd0, sum},
                  $urandom_range(octal_digits({12'd0, sum}), SUM_END - SUM_START));
        for (i = 0; i < nbytes; i++) send_item(FN_BYTE, hdr_buf[i]);
    endtask

    task automatic send_region(input longint n);
        longint i;
        for (i = 0; i < n; i++) send_item(FN_BYTE, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_entry(input t_name_style ns, input logic [SIZE_W-1:0] size,
                              input logic [7:0] etype);
        send_header(ns, size, etype, 1'b0, BLOCK_BYTES);
        send_region(region_len(size));
    endtask

    // extracting: sizes around block edges, directories, name safety
    task automatic test_directed_entries();
        write_list_only(1'b0);
        send_entry(NM_PLAIN, 36'd5, CH_ZERO);
        send_entry(NM_PLAIN, 36'd0, CH_ZERO);          // next header follows directly
        send_entry(NM_DOTS_SAFE, 36'd512, CH_ZERO);
        send_entry(NM_FULL, 36'd513, CH_ZERO);
        send_entry(NM_PLAIN, 36'd0, CH_DIR);
        send_entry(NM_PLAIN, 36'd3, CH_DIR);           // directory region is skipped
        send_entry(NM_EMPTY, 36'd2, CH_ZERO);
        send_entry(NM_ABS, 36'd9, CH_ZERO);
        send_entry(NM_DOTDOT, 36'd600, CH_ZERO);
        send_entry(NM_DOTS_AFTER_END, 36'd1, CH_ZERO);
        send_entry(NM_NOISE, 36'd4, 8'hFF);
    endtask

    // listing: regions consumed, no payload
    task automatic test_list_mode();
        write_list_only(1'b1);
        send_entry(NM_PLAIN, 36'd700, CH_ZERO);
        send_entry(NM_PLAIN, 36'd0, CH_DIR);
        send_entry(NM_ABS, 36'd20, CH_ZERO);
        write_list_only(1'b0);
    endtask

    // results held off long enough for the input side to stall
    task automatic test_backpressure();
        send_header(NM_PLAIN, 36'd700, CH_ZERO, 1'b0, BLOCK_BYTES);
        rx_hold_left = HOLD_CYCLES;
        send_region(region_len(36'd700));
        // sender waits for every result before going on
        wait_results_done();
        send_entry(NM_PLAIN, 36'd30, CH_ZERO);
    endtask

    task automatic test_random_archive();
        int          entries;
        int          start_items;
        t_name_style ns;
        logic [SIZE_W-1:0] size;
        logic [7:0]  etype;
        entries = 0;
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS || entries < 8) begin
            if (entries % 5 == 4) write_list_only(1'($urandom_range(0, 1)));
            steady = (entries == 2 || entries == 3);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: ns = NM_PLAIN;
                4: ns = NM_DOTS_SAFE;
                5: ns = NM_EMPTY;
                6: ns = NM_ABS;
                7: ns = NM_DOTDOT;
                8: ns = NM_NOISE;
                default: ns = ($urandom_range(0, 1) == 1) ? NM_FULL : NM_DOTS_AFTER_END;
            endcase
            case ($urandom_range(0, 9))
                0: size = 36'd0;
                1: size = SIZE_W'($urandom_range(511, 513));
                2: size = SIZE_W'($urandom_range(1024, 1600));
                default: size = SIZE_W'($urandom_range(1, 700));
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: etype = CH_ZERO;
                5, 6: etype = CH_DIR;
                7: etype = 8'h00;
                default: etype = 8'($urandom_range(0, 255));
            endcase
            send_entry(ns, size, etype);
            entries++;
        end
        steady = 1'b0;
    endtask

    // one end condition, then input that the stopped reader ignores
    task automatic test_archive_end();
        t_end_style es;
        int i;
        write_list_only(1'($urandom_range(0, 1)));
        es = t_end_style'($urandom_range(0, 5));
        case (es)
            END_ZERO_BLOCK: begin
                for (i = 0; i < BLOCK_BYTES; i++) send_item(FN_BYTE, 8'h00);
            end
            END_AT_BOUNDARY: send_item(FN_END, 8'($urandom_range(0, 255)));
            END_IN_HEADER: begin
                send_header(NM_PLAIN, 36'd10, CH_ZERO, 1'b0,
                            $urandom_range(1, BLOCK_BYTES - 1));
                send_item(FN_END, 8'($urandom_range(0, 255)));
            end
            END_IN_HUGE_DATA: begin
                send_header(NM_PLAIN, {SIZE_W{1'b1}}, CH_ZERO, 1'b0, BLOCK_BYTES);
                send_region(longint'($urandom_range(1, 700)));
                // register change inside an entry only counts at the end
                write_list_only(1'($urandom_range(0, 1)));
                send_item(FN_END, 8'($urandom_range(0, 255)));
            end
            END_BAD_SUM: send_header(NM_PLAIN, SIZE_W'($urandom_range(0, 700)), CH_ZERO,
                                     1'b1, BLOCK_BYTES);
            default: begin
                send_header(NM_PLAIN, 36'd300, CH_ZERO, 1'b0, BLOCK_BYTES);
                send_region(longint'($urandom_range(1, BLOCK_BYTES - 1)));
                send_item(FN_END, 8'($urandom_range(0, 255)));
            end
        endcase
        repeat (20) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endtask

    // result side ready, with random and long holds
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            i_out_ready <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end else if (steady) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= 10);
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_reader_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with none expected", 64'(o_result_kind), 64'(0));
            end else begin
                want = expected_results.pop_front();
                if (o_result_kind !== want.kind)
                    report_mismatch("result_kind", 64'(o_result_kind), 64'(want.kind));
                if (o_payload_byte !== want.payload)
                    report_mismatch("payload_byte", 64'(o_payload_byte),
                                    64'(want.payload));
                if (o_last_payload !== want.last_flag)
                    report_mismatch("last_payload", 64'(o_last_payload),
                                    64'(want.last_flag));
                if (o_entry_size !== want.entry_size)
                    report_mismatch("entry_size", 64'(o_entry_size),
                                    64'(want.entry_size));
                if (o_entry_type !== want.entry_type)
                    report_mismatch("entry_type", 64'(o_entry_type),
                                    64'(want.entry_type));
                if (o_name_unsafe !== want.name_bad)
                    report_mismatch("name_unsafe", 64'(o_name_unsafe), 64'(want.name_bad));
            end
        end
    end

    initial begin : run_tests
        int wait_count;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 1'b0;
        i_in_valid    <= 1'b0;
        i_func        <= FN_BYTE;
        i_byte_value  <= 8'h00;
        list_only_m   = 1'b0;
        rd_phase      = RD_HEADER;
        region_left   = '0;
        payload_left  = '0;
        skip_entry    = 1'b0;
        clear_header_state();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_entries();
        test_list_mode();
        test_backpressure();
        test_random_archive();
        test_archive_end();

        // drain, then watch a while for stray results
        i_in_valid <= 1'b0;
        wait_count = 0;
        while (expected_results.size() != 0 && wait_count < 5000) begin
            @(posedge i_clk);
            wait_count++;
        end
        repeat (20) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch("results never delivered", 64'(expected_results.size()),
                            64'(0));
        if (mismatch_count == 0)
            $display("ustar_archive_stream_reader_core: match");
        else
            $display("ustar_archive_stream_reader_core: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
rtl/uasr_pkg.sv
rtl/uasr_hdr_acc.sv
rtl/ustar_archive_stream_reader_core.sv
rtl/uasr_checker.sv
bench/tb.sv
